// File: hw/rtl/message_retry_table_macros.svh
// Assertion macros for the message retry table.
// Used by the top level only; no other dependencies.
`ifndef MESSAGE_RETRY_TABLE_MACROS_SVH
`define MESSAGE_RETRY_TABLE_MACROS_SVH

// same-cycle implication
`define MRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("message_retry_table: assertion failed");

// next-cycle implication
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("message_retry_table: assertion failed");

`endif

// File: hw/rtl/mrt_pkg.sv
// Types and constants for the message retry table.
// No dependencies; used by the cells, the head unit, the top level and the testbench.
`timescale 1ns / 1ps

package mrt_pkg;

   localparam int KEY_W      = 54;
   localparam int ID_W       = 16;
   localparam int TIME_W     = 32;
   localparam int SLOT_FW    = 4;
   localparam int CNT_W      = 8;
   localparam int LIMIT_W    = 7;
   localparam int INTV_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W:0]          STALE_MARGIN = 33'd86400;
   localparam logic signed [CNT_W-1:0]  CNT_ACKED    = -8'sd2;
   localparam logic signed [CNT_W-1:0]  CNT_RECEIVED = -8'sd1;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL = 2'd1;

   typedef enum logic [1:0] {
      FUNC_SEND = 2'd0,
      FUNC_RECV = 2'd1,
      FUNC_ACK  = 2'd2,
      FUNC_TICK = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      EVT_STORED   = 3'd0,
      EVT_REJECTED = 3'd1,
      EVT_ACK_HIT  = 3'd2,
      EVT_ACK_MISS = 3'd3,
      EVT_RETX     = 3'd4,
      EVT_SCAN_END = 3'd5
   } evt_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      HD_PASS,
      HD_ACK,
      HD_TICK,
      HD_WRITE
   } hd_mode_type;

   typedef struct packed {
      func_type            func;
      logic [KEY_W-1:0]    peer_key;
      logic [ID_W-1:0]     msg_id;
      logic [TIME_W-1:0]   now;
   } req_word_type;

   typedef struct packed {
      evt_type                   event_res;
      logic [SLOT_FW-1:0]        slot;
      logic [KEY_W-1:0]          peer_out;
      logic [ID_W-1:0]           id_out;
      logic signed [CNT_W-1:0]   retries_left;
      logic                      last;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_word_type;

   typedef struct packed {
      logic                     valid;
      logic                     rx;
      logic [KEY_W-1:0]         peer;
      logic [ID_W-1:0]          id;
      logic [TIME_W-1:0]        stamp;
      logic signed [CNT_W-1:0]  retries;
   } rec_type;

   typedef struct packed {
      hd_mode_type              mode;
      logic                     write_here;
      logic                     rx;
      logic [KEY_W-1:0]         peer;
      logic [ID_W-1:0]          id;
      logic [TIME_W-1:0]        now;
      logic [INTV_W-1:0]        interval;
      logic signed [CNT_W-1:0]  cnt;
      logic [TIME_W:0]          least;
   } hd_ctrl_type;

   typedef struct packed {
      logic match;
      logic free;
      logic older;
      logic retx;
   } hd_flags_type;

endpackage

// File: hw/rtl/mrt_chan_if.sv
// Valid/ready channel carrying one word of a package payload type.
// Needs no package itself; the payload type is bound at instantiation.
`timescale 1ns / 1ps

interface mrt_chan_if #(parameter type word_type = logic) ();

   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/message_retry_table.sv
// Channel    | dir | word fields
// req_bus    | in  | func, peer_key, msg_id, now
// rsp_bus    | out | event_res, slot, peer_out, id_out, retries_left, last
// csr_bus    | in  | reg_index (0 retry_limit, 1 retry_interval), wdata
// The records rotate through a ring of TABLE_SLOTS cells.
// Send/receive: two passes (search, then write).
// Ack and tick: one pass; a send or receive with an empty key is rejected without a pass.
// A tick pass stops rotating while the output register holds an untaken word.
// Synchronous reset invalidates all records and restores the register defaults.
// Top level of the message retry table; depends on mrt_pkg, mrt_chan_if, mrt_cell, mrt_head.
`timescale 1ns / 1ps
`include "message_retry_table_macros.svh"

module message_retry_table #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mrt_chan_if.sink    req_bus,
   mrt_chan_if.source  rsp_bus,
   mrt_chan_if.sink    csr_bus
);
   import mrt_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

   function automatic logic [SLOT_FW-1:0] slot_field(input logic [SLOT_W-1:0] i);
      logic [SLOT_W+SLOT_FW-1:0] w;
      w = {{SLOT_FW{1'b0}}, i};
      return w[SLOT_FW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   func_type                func_ff, func_in;
   logic                    rx_ff, rx_in;
   logic                    reject_ff, reject_in;
   logic [KEY_W-1:0]        peer_ff, peer_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic signed [CNT_W-1:0] cnt_ff, cnt_in;

   logic              match_hit_ff, match_hit_in;
   logic [SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic              free_hit_ff, free_hit_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [TIME_W:0]   least_ff, least_in;
   logic [SLOT_W-1:0] old_idx_ff, old_idx_in;
   logic [SLOT_W-1:0] pick;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [INTV_W-1:0]  interval_ff, interval_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;

   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic req_fire, csr_fire, out_free, adv, idx_last, store_op;

   rec_type      ring [TABLE_SLOTS];
   rec_type      head_out;
   hd_ctrl_type  hd_ctrl;
   hd_flags_type hd_flags;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign idx_last = (idx_ff == LAST_IDX);
   assign store_op = (func_ff == FUNC_SEND) || (func_ff == FUNC_RECV);
   assign adv      = ((state_ff == S_SCAN) && ((func_ff != FUNC_TICK) || out_free)) ||
                     (state_ff == S_WRITE);
   assign pick     = match_hit_ff ? match_idx_ff : (free_hit_ff ? free_idx_ff : old_idx_ff);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   // ring: cell k takes from cell k+1, the last cell takes the head unit's output
   genvar k;
   generate
      for (k = 0; k < TABLE_SLOTS; k++) begin : g_cell
         if (k == TABLE_SLOTS - 1) begin : g_tail
            mrt_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .shift   (adv),
               .rec_in  (head_out),
               .rec_out (ring[k])
            );
         end else begin : g_body
            mrt_cell u_cell (
               .clock   (clock),
               .reset   (reset),
               .shift   (adv),
               .rec_in  (ring[k+1]),
               .rec_out (ring[k])
            );
         end
      end
   endgenerate

   always_comb begin
      hd_ctrl.mode = HD_PASS;
      case (state_ff)
         S_SCAN: begin
            if (func_ff == FUNC_ACK) begin
               hd_ctrl.mode = HD_ACK;
            end else if (func_ff == FUNC_TICK) begin
               hd_ctrl.mode = HD_TICK;
            end
         end
         S_WRITE: begin
            hd_ctrl.mode = HD_WRITE;
         end
         default: begin
            hd_ctrl.mode = HD_PASS;
         end
      endcase
      hd_ctrl.write_here = (idx_ff == pick);
      hd_ctrl.rx         = rx_ff;
      hd_ctrl.peer       = peer_ff;
      hd_ctrl.id         = id_ff;
      hd_ctrl.now        = now_ff;
      hd_ctrl.interval   = interval_ff;
      hd_ctrl.cnt        = cnt_ff;
      hd_ctrl.least      = least_ff;
   end

   mrt_head u_head (
      .hd_rec  (ring[0]),
      .ctrl    (hd_ctrl),
      .rec_out (head_out),
      .flags   (hd_flags)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (((req_bus.data.func == FUNC_SEND) || (req_bus.data.func == FUNC_RECV)) &&
                   (req_bus.data.peer_key == '0)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (adv && idx_last) begin
               state_in = store_op ? S_WRITE : S_DONE;
            end
         end
         S_WRITE: begin
            if (idx_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      func_in      = func_ff;
      rx_in        = rx_ff;
      reject_in    = reject_ff;
      peer_in      = peer_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      match_hit_in = match_hit_ff;
      match_idx_in = match_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      least_in     = least_ff;
      old_idx_in   = old_idx_ff;
      limit_in     = limit_ff;
      interval_in  = interval_ff;
      next_id_in   = next_id_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (csr_fire) begin
         case (csr_bus.data.reg_index)
            CSR_RETRY_LIMIT:    limit_in    = csr_bus.data.wdata[LIMIT_W-1:0];
            CSR_RETRY_INTERVAL: interval_in = csr_bus.data.wdata[INTV_W-1:0];
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end

      if (req_fire) begin
         func_in      = req_bus.data.func;
         peer_in      = req_bus.data.peer_key;
         now_in       = req_bus.data.now;
         rx_in        = (req_bus.data.func == FUNC_RECV);
         id_in        = req_bus.data.msg_id;
         cnt_in       = CNT_ACKED;
         reject_in    = ((req_bus.data.func == FUNC_SEND) || (req_bus.data.func == FUNC_RECV)) &&
                        (req_bus.data.peer_key == '0);
         match_hit_in = 1'b0;
         free_hit_in  = 1'b0;
         old_idx_in   = '0;
         idx_in       = '0;
         least_in     = {1'b0, req_bus.data.now} + STALE_MARGIN;
         if ((req_bus.data.func == FUNC_SEND) && (req_bus.data.peer_key != '0)) begin
            next_id_in = next_id_ff + 16'd1;
            id_in      = next_id_ff + 16'd1;
            cnt_in     = (limit_ff == '0) ? CNT_ACKED : $signed({1'b0, limit_ff});
         end else if (req_bus.data.func == FUNC_RECV) begin
            cnt_in = CNT_RECEIVED;
         end
      end

      if (adv) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
      end

      if ((state_ff == S_SCAN) && adv) begin
         if (hd_flags.match && !match_hit_ff) begin
            match_hit_in = 1'b1;
            match_idx_in = idx_ff;
         end
         if (hd_flags.free && !free_hit_ff) begin
            free_hit_in = 1'b1;
            free_idx_in = idx_ff;
         end
         if (hd_flags.older) begin
            least_in   = {1'b0, ring[0].stamp};
            old_idx_in = idx_ff;
         end
         if ((func_ff == FUNC_TICK) && hd_flags.retx) begin
            rsp_valid_in        = 1'b1;
            rsp_in.event_res    = EVT_RETX;
            rsp_in.slot         = slot_field(idx_ff);
            rsp_in.peer_out     = ring[0].peer;
            rsp_in.id_out       = ring[0].id;
            rsp_in.retries_left = head_out.retries;
            rsp_in.last         = 1'b0;
         end
      end

      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in        = 1'b1;
         rsp_in.slot         = '0;
         rsp_in.peer_out     = '0;
         rsp_in.id_out       = '0;
         rsp_in.retries_left = '0;
         rsp_in.last         = 1'b1;
         if (reject_ff) begin
            rsp_in.event_res = EVT_REJECTED;
         end else if (store_op) begin
            rsp_in.event_res    = EVT_STORED;
            rsp_in.slot         = slot_field(pick);
            rsp_in.peer_out     = peer_ff;
            rsp_in.id_out       = id_ff;
            rsp_in.retries_left = cnt_ff;
         end else if (func_ff == FUNC_ACK) begin
            if (match_hit_ff) begin
               rsp_in.event_res    = EVT_ACK_HIT;
               rsp_in.slot         = slot_field(match_idx_ff);
               rsp_in.peer_out     = peer_ff;
               rsp_in.id_out       = id_ff;
               rsp_in.retries_left = CNT_ACKED;
            end else begin
               rsp_in.event_res = EVT_ACK_MISS;
            end
         end else begin
            rsp_in.event_res = EVT_SCAN_END;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= 7'd3;
         interval_ff  <= 16'd60;
         next_id_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         interval_ff  <= interval_in;
         next_id_ff   <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      rx_ff        <= rx_in;
      reject_ff    <= reject_in;
      peer_ff      <= peer_in;
      id_ff        <= id_in;
      now_ff       <= now_in;
      cnt_ff       <= cnt_in;
      match_hit_ff <= match_hit_in;
      match_idx_ff <= match_idx_in;
      free_hit_ff  <= free_hit_in;
      free_idx_ff  <= free_idx_in;
      least_ff     <= least_in;
      old_idx_ff   <= old_idx_in;
      rsp_ff       <= rsp_in;
   end

   // ring is back home whenever the block is idle
   `MRT_ASSERT_NOW(a_ring_home, clock, reset, state_ff == S_IDLE, idx_ff == '0)
   `MRT_ASSERT_NEXT(a_store_two_pass, clock, reset, (state_ff == S_SCAN) && adv && idx_last && store_op, state_ff == S_WRITE)
   `MRT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, state_ff != S_IDLE)

endmodule

// File: hw/rtl/mrt_cell.sv
// One record cell of the rotating table; takes its neighbor's record on shift.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  mrt_pkg::rec_type rec_in,
   output mrt_pkg::rec_type rec_out
);
   import mrt_pkg::*;

   rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (shift) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

// File: hw/rtl/mrt_head.sv
// Head unit of the ring: compares, ages and rewrites the record leaving cell 0.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_head (
   input  mrt_pkg::rec_type      hd_rec,
   input  mrt_pkg::hd_ctrl_type  ctrl,
   output mrt_pkg::rec_type      rec_out,
   output mrt_pkg::hd_flags_type flags
);
   import mrt_pkg::*;

   logic [TIME_W-1:0]       age;
   logic signed [CNT_W-1:0] dec;

   assign age = ctrl.now - hd_rec.stamp;
   assign dec = hd_rec.retries - 8'sd1;

   always_comb begin
      flags.match = hd_rec.valid && (hd_rec.rx == ctrl.rx) && (hd_rec.id == ctrl.id) &&
                    (hd_rec.peer == ctrl.peer);
      flags.free  = !hd_rec.valid;
      flags.older = hd_rec.valid && ({1'b0, hd_rec.stamp} < ctrl.least);
      flags.retx  = hd_rec.valid && (hd_rec.retries > 8'sd0) && !age[TIME_W-1] &&
                    (age > {{(TIME_W-INTV_W){1'b0}}, ctrl.interval});
   end

   always_comb begin
      rec_out = hd_rec;
      case (ctrl.mode)
         HD_ACK: begin
            if (flags.match) begin
               rec_out.retries = CNT_ACKED;
            end
         end
         HD_TICK: begin
            if (flags.retx) begin
               rec_out.retries = dec;
               if (dec > 8'sd0) begin
                  rec_out.stamp = ctrl.now + {{(TIME_W-INTV_W){1'b0}}, ctrl.interval};
               end
            end
         end
         HD_WRITE: begin
            if (ctrl.write_here) begin
               rec_out.valid   = 1'b1;
               rec_out.rx      = ctrl.rx;
               rec_out.peer    = ctrl.peer;
               rec_out.id      = ctrl.id;
               rec_out.stamp   = ctrl.now;
               rec_out.retries = ctrl.cnt;
            end
         end
         default: begin
            rec_out = hd_rec;
         end
      endcase
   end

endmodule

// File: bench/tb.sv
// Self-checking testbench for message_retry_table: a directed table, then random
// traffic, checked word by word against a behavioral copy of the retry table.
// Depends on mrt_pkg, mrt_chan_if and the message_retry_table RTL.
`timescale 1ns / 1ps

module tb;
   import mrt_pkg::*;

   localparam int SLOTS = 16;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
   localparam int HOLD_CYCLES = 400;
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_ONE = 54'h1;
   localparam logic [KEY_W-1:0] KEY_ALT = 54'h2AAAAAAAAAAAAA;

   typedef struct {
      bit                        cfg;
      logic [LIMIT_W-1:0]        lim;
      logic [INTV_W-1:0]         intv;
      func_type                  func;
      logic [KEY_W-1:0]          peer;
      logic [ID_W-1:0]           id;
      logic [TIME_W-1:0]         now;
      int                        rep;
      bit                        typed;
      rsp_word_type              want;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrt_chan_if #(.word_type(req_word_type)) req_bus ();
   mrt_chan_if #(.word_type(rsp_word_type)) rsp_bus ();
   mrt_chan_if #(.word_type(csr_word_type)) csr_bus ();

   message_retry_table #(.TABLE_SLOTS(SLOTS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // predicted retry table
   logic                    rec_used  [SLOTS];
   logic                    rec_rx    [SLOTS];
   logic [KEY_W-1:0]        rec_peer  [SLOTS];
   logic [ID_W-1:0]         rec_id    [SLOTS];
   logic [TIME_W-1:0]       rec_stamp [SLOTS];
   logic signed [CNT_W-1:0] rec_cnt   [SLOTS];
   logic [ID_W-1:0]         id_counter = '0;
   logic [LIMIT_W-1:0]      cfg_limit = 7'd3;
   logic [INTV_W-1:0]       cfg_interval = 16'd60;

   rsp_word_type due_words [$];
   step_row_type dir_rows  [$];
   logic [KEY_W-1:0] peer_pool [16];
   logic [TIME_W-1:0] clock_now = '0;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_trigger = 0;
   int fail_count = 0;
   int words_sent = 0;
   int words_seen = 0;
   int retx_seen = 0;
   int reject_seen = 0;
   int ack_hit_seen = 0;
   int cfg_writes = 0;

   function automatic rsp_word_type make_word(evt_type e, logic [SLOT_FW-1:0] s,
         logic [KEY_W-1:0] p, logic [ID_W-1:0] i, logic signed [CNT_W-1:0] c, logic l);
      rsp_word_type r;
      r.event_res = e;
      r.slot = s;
      r.peer_out = p;
      r.id_out = i;
      r.retries_left = c;
      r.last = l;
      return r;
   endfunction

   function automatic int find_record(logic [KEY_W-1:0] p, logic [ID_W-1:0] i, logic rx);
      for (int s = 0; s < SLOTS; s++)
         if (rec_used[s] && rec_id[s] == i && rec_rx[s] == rx && rec_peer[s] == p)
            return s;
      return -1;
   endfunction

   // first free slot, else first smallest stamp below now + margin, else slot 0
   function automatic int pick_victim(logic [TIME_W-1:0] t);
      logic [TIME_W:0] least;
      int pick;
      least = {1'b0, t} + STALE_MARGIN;
      pick = 0;
      for (int s = 0; s < SLOTS; s++) begin
         if (!rec_used[s])
            return s;
         if ({1'b0, rec_stamp[s]} < least) begin
            least = {1'b0, rec_stamp[s]};
            pick = s;
         end
      end
      return pick;
   endfunction

   function automatic void retry_table_step(req_word_type w);
      int s;
      logic [ID_W-1:0] id;
      logic signed [CNT_W-1:0] cnt;
      logic [TIME_W-1:0] age;
      if (w.func == FUNC_SEND || w.func == FUNC_RECV) begin
         if (w.peer_key == '0) begin
            due_words.push_back(make_word(EVT_REJECTED, '0, '0, '0, '0, 1'b1));
            return;
         end
         if (w.func == FUNC_SEND) begin
            id_counter = id_counter + 1'b1;
            id = id_counter;
            cnt = (cfg_limit == '0) ? CNT_ACKED : {1'b0, cfg_limit};
         end else begin
            id = w.msg_id;
            cnt = CNT_RECEIVED;
         end
         s = find_record(w.peer_key, id, w.func == FUNC_RECV);
         if (s < 0)
            s = pick_victim(w.now);
         rec_used[s] = 1'b1;
         rec_stamp[s] = w.now;
         rec_id[s] = id;
         rec_cnt[s] = cnt;
         rec_rx[s] = (w.func == FUNC_RECV);
         rec_peer[s] = w.peer_key;
         due_words.push_back(make_word(EVT_STORED, SLOT_FW'(s), w.peer_key, id, cnt, 1'b1));
      end else if (w.func == FUNC_ACK) begin
         s = find_record(w.peer_key, w.msg_id, 1'b0);
         if (s < 0) begin
            due_words.push_back(make_word(EVT_ACK_MISS, '0, '0, '0, '0, 1'b1));
            return;
         end
         rec_cnt[s] = CNT_ACKED;
         due_words.push_back(make_word(EVT_ACK_HIT, SLOT_FW'(s), rec_peer[s], rec_id[s],
                                       CNT_ACKED, 1'b1));
      end else begin
         for (s = 0; s < SLOTS; s++) begin
            if (!rec_used[s] || rec_cnt[s] <= 0)
               continue;
            age = w.now - rec_stamp[s];
            if (age[TIME_W-1] || age <= {16'b0, cfg_interval})
               continue;
            rec_cnt[s] = rec_cnt[s] - 8'sd1;
            if (rec_cnt[s] > 0)
               rec_stamp[s] = w.now + {16'b0, cfg_interval};
            due_words.push_back(make_word(EVT_RETX, SLOT_FW'(s), rec_peer[s], rec_id[s],
                                          rec_cnt[s], 1'b0));
         end
         due_words.push_back(make_word(EVT_SCAN_END, '0, '0, '0, '0, 1'b1));
      end
   endfunction

   function automatic void check_rsp(rsp_word_type got);
      rsp_word_type want;
      words_seen++;
      if (got.event_res == EVT_RETX) retx_seen++;
      if (got.event_res == EVT_REJECTED) reject_seen++;
      if (got.event_res == EVT_ACK_HIT) ack_hit_seen++;
      if (due_words.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected word: evt=%0d slot=%0d peer=%h id=%h cnt=%0d last=%b",
                     got.event_res, got.slot, got.peer_out, got.id_out,
                     got.retries_left, got.last);
         return;
      end
      want = due_words.pop_front();
      if (got.event_res !== want.event_res || got.slot !== want.slot ||
          got.peer_out !== want.peer_out || got.id_out !== want.id_out ||
          got.retries_left !== want.retries_left || got.last !== want.last) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("mismatch: want evt=%0d slot=%0d peer=%h id=%h cnt=%0d last=%b",
                     want.event_res, want.slot, want.peer_out, want.id_out,
                     want.retries_left, want.last);
            $display("          got  evt=%0d slot=%0d peer=%h id=%h cnt=%0d last=%b",
                     got.event_res, got.slot, got.peer_out, got.id_out,
                     got.retries_left, got.last);
         end
      end
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      do k = KEY_W'({$urandom(), $urandom()}); while (k == '0);
      return k;
   endfunction

   function automatic void add_req(func_type f, logic [KEY_W-1:0] p, logic [ID_W-1:0] i,
         logic [TIME_W-1:0] t, int rep);
      step_row_type r;
      r = '{cfg: 1'b0, lim: '0, intv: '0, func: f, peer: p, id: i, now: t, rep: rep,
            typed: 1'b0, want: '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_want(func_type f, logic [KEY_W-1:0] p, logic [ID_W-1:0] i,
         logic [TIME_W-1:0] t, rsp_word_type want);
      step_row_type r;
      r = '{cfg: 1'b0, lim: '0, intv: '0, func: f, peer: p, id: i, now: t, rep: 1,
            typed: 1'b1, want: want};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_cfg(logic [LIMIT_W-1:0] lim, logic [INTV_W-1:0] intv);
      step_row_type r;
      r = '{cfg: 1'b1, lim: lim, intv: intv, func: FUNC_TICK, peer: '0, id: '0, now: '0,
            rep: 0, typed: 1'b0, want: '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void build_rows();
      add_want(FUNC_SEND, '0, 16'hFFFF, 32'hFFFFFFFF,
               make_word(EVT_REJECTED, '0, '0, '0, '0, 1'b1));
      add_want(FUNC_RECV, '0, 16'h1234, 32'h0, make_word(EVT_REJECTED, '0, '0, '0, '0, 1'b1));
      add_want(FUNC_ACK, '0, 16'h0, 32'h0, make_word(EVT_ACK_MISS, '0, '0, '0, '0, 1'b1));
      add_want(FUNC_TICK, KEY_ONES, 16'hFFFF, 32'h0,
               make_word(EVT_SCAN_END, '0, '0, '0, '0, 1'b1));
      add_want(FUNC_SEND, KEY_ONES, 16'hFFFF, 32'd0,
               make_word(EVT_STORED, 4'd0, KEY_ONES, 16'd1, 8'sd3, 1'b1));
      add_want(FUNC_RECV, KEY_ONES, 16'd1, 32'd5,
               make_word(EVT_STORED, 4'd1, KEY_ONES, 16'd1, CNT_RECEIVED, 1'b1));
      add_want(FUNC_RECV, KEY_ONES, 16'd1, 32'd7,
               make_word(EVT_STORED, 4'd1, KEY_ONES, 16'd1, CNT_RECEIVED, 1'b1));
      add_want(FUNC_ACK, KEY_ONES, 16'd1, 32'd9,
               make_word(EVT_ACK_HIT, 4'd0, KEY_ONES, 16'd1, CNT_ACKED, 1'b1));
      add_want(FUNC_ACK, KEY_ONES, 16'd2, 32'd9, make_word(EVT_ACK_MISS, '0, '0, '0, '0, 1'b1));
      add_want(FUNC_SEND, KEY_ONE, 16'd0, 32'd100,
               make_word(EVT_STORED, 4'd2, KEY_ONE, 16'd2, 8'sd3, 1'b1));
      // age equal to the interval does not retransmit
      add_want(FUNC_TICK, '0, 16'd0, 32'd160, make_word(EVT_SCAN_END, '0, '0, '0, '0, 1'b1));
      add_req(FUNC_TICK, '0, 16'd0, 32'd161, 1);
      add_req(FUNC_TICK, '0, 16'd0, 32'h800000DD, 1);
      add_req(FUNC_TICK, '0, 16'd0, 32'd282, 1);
      add_req(FUNC_TICK, '0, 16'd0, 32'd403, 1);
      add_cfg(7'd0, 16'd60);
      add_want(FUNC_SEND, KEY_ONE, 16'd0, 32'd400,
               make_word(EVT_STORED, 4'd3, KEY_ONE, 16'd3, CNT_ACKED, 1'b1));
      add_cfg(7'd127, 16'hFFFF);
      add_want(FUNC_SEND, KEY_ALT, 16'd0, 32'hFFFFFF00,
               make_word(EVT_STORED, 4'd4, KEY_ALT, 16'd4, 8'sd127, 1'b1));
      add_req(FUNC_TICK, '0, 16'd0, 32'h0000FF00, 1);
      add_cfg(7'd127, 16'd0);
      add_req(FUNC_TICK, '0, 16'd0, 32'h0001FF00, 1);
      add_want(FUNC_ACK, KEY_ALT, 16'd4, 32'd0,
               make_word(EVT_ACK_HIT, 4'd4, KEY_ALT, 16'd4, CNT_ACKED, 1'b1));
      // fill the table with equal stamps, then force the oldest-slot choice
      add_req(FUNC_SEND, 54'h100, 16'd0, 32'hFFFF0000, 11);
      add_req(FUNC_SEND, 54'h155, 16'd0, 32'd600, 1);
      add_req(FUNC_RECV, 54'h100, 16'd5, 32'd600, 1);
      add_cfg(7'd3, 16'd60);
   endfunction

   function automatic req_word_type pick_req();
      req_word_type w;
      int r;
      int s;
      r = $urandom_range(0, 99);
      w.func = FUNC_SEND;
      w.peer_key = peer_pool[$urandom_range(0, 15)];
      w.msg_id = 16'($urandom());
      if (r < 30) begin
         clock_now = clock_now + $urandom_range(0, 5);
      end else if (r < 45) begin
         w.func = FUNC_RECV;
         if ($urandom_range(0, 1) == 0) w.msg_id = 16'($urandom_range(0, 7));
         clock_now = clock_now + $urandom_range(0, 5);
      end else if (r < 65) begin
         w.func = FUNC_ACK;
         s = $urandom_range(0, SLOTS - 1);
         if (rec_used[s] && !rec_rx[s] && $urandom_range(0, 3) != 0) begin
            w.peer_key = rec_peer[s];
            w.msg_id = rec_id[s];
         end else begin
            w.msg_id = id_counter - 16'($urandom_range(0, 3));
         end
      end else if (r < 85) begin
         w.func = FUNC_TICK;
         clock_now = clock_now + $urandom_range(0, 2 * int'(cfg_interval) + 2);
      end else if (r < 92) begin
         w.func = func_type'($urandom_range(0, 3));
         w.peer_key = KEY_W'({$urandom(), $urandom()});
         w.now = $urandom();
         return w;
      end else begin
         w.func = ($urandom_range(0, 1) == 0) ? FUNC_SEND : FUNC_RECV;
         w.peer_key = '0;
      end
      w.now = clock_now;
      return w;
   endfunction

   // called at a falling edge; returns at a falling edge with valid left high
   task automatic drive_req(req_word_type w, bit typed, rsp_word_type want);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.data <= w;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      retry_table_step(w);
      if (typed) due_words[due_words.size() - 1] = want;
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (due_words.size() != 0) @(negedge clock);
   endtask

   task automatic set_config(logic [LIMIT_W-1:0] lim, logic [INTV_W-1:0] intv);
      csr_bus.data <= '{reg_index: CSR_RETRY_LIMIT, wdata: {9'b0, lim}};
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      cfg_limit = lim;
      @(negedge clock);
      csr_bus.data <= '{reg_index: CSR_RETRY_INTERVAL, wdata: intv};
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      cfg_interval = intv;
      cfg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic fill_burst();
      req_word_type w;
      rsp_word_type none;
      none = '0;
      w.func = FUNC_SEND;
      for (int k = 0; k < 17; k++) begin
         w.peer_key = random_key();
         w.msg_id = 16'($urandom());
         w.now = 32'hFFFF0000 + $urandom_range(0, 3);
         drive_req(w, 1'b0, none);
      end
      // every stamp now lies far above this time
      w.peer_key = random_key();
      w.now = $urandom_range(0, 1000);
      clock_now = w.now;
      drive_req(w, 1'b0, none);
   endtask

   // result side: random ready, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            check_rsp(rsp_bus.data);
      end
   end

   initial begin
      #3000000;
      $display("timeout with %0d words outstanding", due_words.size());
      $display("FAIL message_retry_table");
      $finish;
   end

   initial begin
      logic [LIMIT_W-1:0] seg_limit [6];
      logic [INTV_W-1:0]  seg_intv  [6];
      req_word_type w;
      rsp_word_type none;
      seg_limit = '{7'd2, 7'd127, 7'd0, 7'd5, 7'd1, 7'd3};
      seg_intv = '{16'd30, 16'hFFFF, 16'd10, 16'd0, 16'd1000, 16'd60};
      none = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      for (int s = 0; s < SLOTS; s++) begin
         rec_used[s] = 1'b0;
         rec_rx[s] = 1'b0;
         rec_peer[s] = '0;
         rec_id[s] = '0;
         rec_stamp[s] = '0;
         rec_cnt[s] = '0;
      end
      peer_pool[0] = KEY_ONES;
      peer_pool[1] = KEY_ONE;
      for (int k = 2; k < 16; k++) peer_pool[k] = random_key();
      build_rows();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 31;
      rsp_idle_pct = 83;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].cfg) begin
            wait_drain();
            set_config(dir_rows[r].lim, dir_rows[r].intv);
         end else begin
            for (int k = 0; k < dir_rows[r].rep; k++) begin
               w.func = dir_rows[r].func;
               w.peer_key = dir_rows[r].peer + KEY_W'(k);
               w.msg_id = dir_rows[r].id;
               w.now = dir_rows[r].now;
               drive_req(w, dir_rows[r].typed, dir_rows[r].want);
            end
         end
      end
      clock_now = 32'd1000;

      for (int seg = 0; seg < 6; seg++) begin
         wait_drain();
         req_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 83 : 0;
         rsp_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 31 : 0;
         set_config(seg_limit[seg], seg_intv[seg]);
         fill_burst();
         for (int n = 0; n < 52; n++) begin
            if (seg == 0 && n == 20) hold_trigger++;
            if (seg == 3 && n == 29) wait_drain();
            drive_req(pick_req(), 1'b0, none);
         end
      end

      req_bus.valid <= 1'b0;
      while (due_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d request words through %0d register settings; %0d result words",
               words_sent, cfg_writes, words_seen);
      $display("including %0d retransmits, %0d acks matched, %0d empty-key rejects",
               retx_seen, ack_hit_seen, reject_seen);
      if (fail_count == 0 && due_words.size() == 0) begin
         $display("PASS message_retry_table");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL message_retry_table");
      end
      $finish;
   end

endmodule
